// ===== sv/slcd_pkg.sv =====
// Shared types, constants and the CRC-8 step function of the sync/length/CRC-8 deframer.
package slcd_pkg;

    // Field widths fixed by the byte stream and the result format
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

    // CRC-8, MSB first, no reflection, no final xor
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    // Parser / emitter states
    typedef enum logic [2:0] {
        ST_SYNC_A,
        ST_SYNC_B,
        ST_TYPE,
        ST_LEN,
        ST_BODY,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_EMIT_EMPTY
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_type;   // type byte transfer
        logic load_len;    // length byte transfer
        logic store_byte;  // payload byte transfer
        logic start_emit;  // CRC byte transfer, rewind position
        logic read_byte;   // read payload store at position
        logic emit_data;   // load output register with a payload result
        logic emit_empty;  // load output register with the empty-frame result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_sync_first;
        logic is_sync_second;
        logic len_ok;      // length fits the store
        logic body_done;   // next byte is the CRC byte
        logic crc_ok;
        logic len_zero;
        logic last;        // current position is the last payload byte
        logic out_free;    // output register can take a result
    } status_t;

    // One byte of CRC-8 update
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_MSB) != '0)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// ===== sv/slcd_rx_if.sv =====
// Input channel: one received byte per transfer.
interface slcd_rx_if;
    logic                        valid;
    logic                        ready;
    logic [slcd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/slcd_res_if.sv =====
// Result channel: one payload byte of an accepted frame, or one empty-frame result, per transfer.
interface slcd_res_if;
    logic                        valid;
    logic                        ready;
    logic [slcd_pkg::BYTE_W-1:0] frame_type;
    logic [slcd_pkg::LEN_W-1:0]  payload_length;
    logic [slcd_pkg::BYTE_W-1:0] payload_byte;
    logic [slcd_pkg::LEN_W-1:0]  byte_position;
    logic                        empty_payload;
    logic                        last_of_frame;

    modport source (output valid, output frame_type, output payload_length,
                    output payload_byte, output byte_position, output empty_payload,
                    output last_of_frame, input ready);
    modport sink   (input valid, input frame_type, input payload_length,
                    input payload_byte, input byte_position, input empty_payload,
                    input last_of_frame, output ready);
endinterface

// ===== sv/sync_length_crc8_deframer.sv =====
// Top level of the sync/length/CRC-8 framed byte-stream deframer.
// Hunts for the two configured sync bytes, then takes a type byte, a length
// byte, the payload and a CRC-8 byte (poly 0x31, MSB first, init 0) computed
// over type, length and payload. Lengths above BUFFER_BYTES-3 drop the frame;
// a bad CRC drops it too. A good frame is delivered as one transfer per
// payload byte, or one transfer flagged empty_payload for a zero length.
// Timing: while parsing, one byte is taken every cycle. After a good CRC byte
// the input is held off while results go out: each payload byte takes a
// registered read of the payload store, then a load of the output register;
// an empty frame takes only the load, and both wait out any output stall. The last result sits
// in the output register while the next frame's bytes are already taken.
// No clearing pass after reset.
module sync_length_crc8_deframer #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [slcd_pkg::BYTE_W-1:0]    cfg_wdata,
    slcd_rx_if.sink                        rx_ch,
    slcd_res_if.source                     res_ch
);

    slcd_pkg::cmd_t    cmd;
    slcd_pkg::status_t status;

    // Parser and result sequencer
    slcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx_ch.valid),
        .in_ready (rx_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, CRC, payload store and output stage
    slcd_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (rx_ch.rx_byte),
        .cmd       (cmd),
        .status    (status),
        .res       (res_ch)
    );

endmodule

// ===== sv/slcd_ctrl.sv =====
// Controller state machine: frame parsing and result sequencing.
module slcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  slcd_pkg::status_t status,
    output slcd_pkg::cmd_t    cmd
);

    slcd_pkg::state_t state_reg;
    slcd_pkg::state_t state_next;
    logic             acc;

    assign acc = in_valid && in_ready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= slcd_pkg::ST_SYNC_A;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slcd_pkg::ST_SYNC_A:
            begin
                if (acc)
                    state_next = status.is_sync_first ? slcd_pkg::ST_SYNC_B
                                                      : slcd_pkg::ST_SYNC_A;
            end
            slcd_pkg::ST_SYNC_B:
            begin
                // second sync value is tested first
                if (acc)
                begin
                    priority if (status.is_sync_second)
                        state_next = slcd_pkg::ST_TYPE;
                    else if (status.is_sync_first)
                        state_next = slcd_pkg::ST_SYNC_B;
                    else
                        state_next = slcd_pkg::ST_SYNC_A;
                end
            end
            slcd_pkg::ST_TYPE:
            begin
                if (acc)
                    state_next = slcd_pkg::ST_LEN;
            end
            slcd_pkg::ST_LEN:
            begin
                if (acc)
                    state_next = status.len_ok ? slcd_pkg::ST_BODY : slcd_pkg::ST_SYNC_A;
            end
            slcd_pkg::ST_BODY:
            begin
                if (acc && status.body_done)
                begin
                    priority if (!status.crc_ok)
                        state_next = slcd_pkg::ST_SYNC_A;
                    else if (status.len_zero)
                        state_next = slcd_pkg::ST_EMIT_EMPTY;
                    else
                        state_next = slcd_pkg::ST_EMIT_RD;
                end
            end
            slcd_pkg::ST_EMIT_RD:
            begin
                state_next = slcd_pkg::ST_EMIT_WR;
            end
            slcd_pkg::ST_EMIT_WR:
            begin
                if (status.out_free)
                    state_next = status.last ? slcd_pkg::ST_SYNC_A : slcd_pkg::ST_EMIT_RD;
            end
            slcd_pkg::ST_EMIT_EMPTY:
            begin
                if (status.out_free)
                    state_next = slcd_pkg::ST_SYNC_A;
            end
            default:
            begin
                state_next = slcd_pkg::ST_SYNC_A;
            end
        endcase
    end

    // Outputs; ready is high in every state that issues an input command
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            slcd_pkg::ST_SYNC_A,
            slcd_pkg::ST_SYNC_B:
            begin
                in_ready = 1'b1;
            end
            slcd_pkg::ST_TYPE:
            begin
                in_ready      = 1'b1;
                cmd.load_type = in_valid;
            end
            slcd_pkg::ST_LEN:
            begin
                in_ready     = 1'b1;
                cmd.load_len = in_valid;
            end
            slcd_pkg::ST_BODY:
            begin
                in_ready       = 1'b1;
                cmd.store_byte = in_valid && !status.body_done;
                cmd.start_emit = in_valid && status.body_done;
            end
            slcd_pkg::ST_EMIT_RD:
            begin
                cmd.read_byte = 1'b1;
            end
            slcd_pkg::ST_EMIT_WR:
            begin
                cmd.emit_data = status.out_free;
            end
            slcd_pkg::ST_EMIT_EMPTY:
            begin
                cmd.emit_empty = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/slcd_datapath.sv =====
// Datapath: sync registers, header capture, CRC, payload store and output register.
module slcd_datapath #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [slcd_pkg::BYTE_W-1:0]          cfg_wdata,
    input  logic [slcd_pkg::BYTE_W-1:0]          rx_byte,
    input  slcd_pkg::cmd_t                       cmd,
    output slcd_pkg::status_t                    status,
    slcd_res_if.source                           res
);

    localparam int BYTE_W      = slcd_pkg::BYTE_W;
    localparam int LEN_W       = slcd_pkg::LEN_W;
    localparam int STORE_DEPTH = BUFFER_BYTES - 3;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic [slcd_pkg::BYTE_W-1:0] sync_first_reg;
    logic [slcd_pkg::BYTE_W-1:0] sync_second_reg;
    logic [slcd_pkg::BYTE_W-1:0] type_reg;
    logic [slcd_pkg::LEN_W-1:0]  len_reg;
    logic [slcd_pkg::LEN_W-1:0]  pos_reg;
    logic [slcd_pkg::LEN_W-1:0]  pos_next;
    logic [slcd_pkg::BYTE_W-1:0] crc_reg;
    logic [slcd_pkg::BYTE_W-1:0] crc_next;
    logic [slcd_pkg::BYTE_W-1:0] rd_data_reg;
    logic [slcd_pkg::BYTE_W-1:0] mem [STORE_DEPTH];

    logic                        out_valid_reg;
    logic [slcd_pkg::BYTE_W-1:0] out_type_reg;
    logic [slcd_pkg::LEN_W-1:0]  out_len_reg;
    logic [slcd_pkg::BYTE_W-1:0] out_byte_reg;
    logic [slcd_pkg::LEN_W-1:0]  out_pos_reg;
    logic                        out_empty_reg;
    logic                        out_last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= slcd_pkg::SYNC_FIRST_RST;
            sync_second_reg <= slcd_pkg::SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                slcd_pkg::REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                slcd_pkg::REG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                default:                   sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    // CRC and position updates
    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.load_type)
            crc_next = slcd_pkg::crc8_step(slcd_pkg::CRC_INIT, rx_byte);
        else if (cmd.load_len || cmd.store_byte)
            crc_next = slcd_pkg::crc8_step(crc_reg, rx_byte);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.load_len || cmd.start_emit)
            pos_next = '0;
        else if (cmd.store_byte || cmd.emit_data)
            pos_next = pos_reg + LEN_W'(1);
    end

    // Header, CRC and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= '0;
            len_reg  <= '0;
            pos_reg  <= '0;
            crc_reg  <= slcd_pkg::CRC_INIT;
        end
        else
        begin
            if (cmd.load_type)
                type_reg <= rx_byte;
            if (cmd.load_len)
                len_reg <= rx_byte[slcd_pkg::LEN_W-1:0];
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // Payload store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
            mem[pos_reg[ADDR_W-1:0]] <= rx_byte;
        if (cmd.read_byte)
            rd_data_reg <= mem[pos_reg[ADDR_W-1:0]];
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_data || cmd.emit_empty)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_data)
        begin
            out_type_reg  <= type_reg;
            out_len_reg   <= len_reg;
            out_byte_reg  <= rd_data_reg;
            out_pos_reg   <= pos_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= status.last;
        end
        else if (cmd.emit_empty)
        begin
            out_type_reg  <= type_reg;
            out_len_reg   <= '0;
            out_byte_reg  <= '0;
            out_pos_reg   <= '0;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.frame_type     = out_type_reg;
    assign res.payload_length = out_len_reg;
    assign res.payload_byte   = out_byte_reg;
    assign res.byte_position  = out_pos_reg;
    assign res.empty_payload  = out_empty_reg;
    assign res.last_of_frame  = out_last_reg;

    // Status to the controller
    always_comb
    begin
        status.is_sync_first  = (rx_byte == sync_first_reg);
        status.is_sync_second = (rx_byte == sync_second_reg);
        status.len_ok         = (rx_byte <= BYTE_W'(STORE_DEPTH));
        status.body_done      = (pos_reg == len_reg);
        status.crc_ok         = (rx_byte == crc_reg);
        status.len_zero       = (len_reg == '0);
        status.last           = ((pos_reg + LEN_W'(1)) == len_reg);
        status.out_free       = !out_valid_reg || res.ready;
    end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sync/length/CRC-8 deframer.
module testbench;

    localparam int BUFFER_BYTES = 64;
    localparam int STORE_DEPTH  = BUFFER_BYTES - 3;

    // One payload result as it leaves the block
    typedef struct packed {
        logic [7:0] frame_type;
        logic [5:0] payload_length;
        logic [7:0] payload_byte;
        logic [5:0] byte_position;
        logic       empty_payload;
        logic       last_of_frame;
    } frame_result_t;

    // Tracks the parser state, predicts the delivered payload and checks it
    class frame_scoreboard;
        logic [7:0]       sync_first;
        logic [7:0]       sync_second;
        slcd_pkg::state_t phase;
        logic [7:0]       held_type;
        logic [5:0]       held_len;
        logic [6:0]       bytes_left;
        logic [5:0]       wr_pos;
        logic [7:0]       crc;
        logic [7:0]       store [STORE_DEPTH];
        frame_result_t    expected_results [$];
        int               mismatches;

        function new();
            sync_first  = slcd_pkg::SYNC_FIRST_RST;
            sync_second = slcd_pkg::SYNC_SECOND_RST;
            phase       = slcd_pkg::ST_SYNC_A;
            held_type   = '0;
            held_len    = '0;
            bytes_left  = '0;
            wr_pos      = '0;
            crc         = slcd_pkg::CRC_INIT;
            mismatches  = 0;
        endfunction

        // Bit-serial CRC-8 update, MSB first
        static function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                if (r[7] ^ b[i])
                    r = {r[6:0], 1'b0} ^ slcd_pkg::CRC_POLY;
                else
                    r = {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function void write_reg(logic [slcd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
            if (idx == slcd_pkg::REG_SYNC_FIRST)
                sync_first = v;
            else if (idx == slcd_pkg::REG_SYNC_SECOND)
                sync_second = v;
        endfunction

        function string show(frame_result_t r);
            return $sformatf("type=%02h len=%0d byte=%02h pos=%0d empty=%0b last=%0b",
                             r.frame_type, r.payload_length, r.payload_byte,
                             r.byte_position, r.empty_payload, r.last_of_frame);
        endfunction

        function void fail(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void push_result(frame_result_t r);
            expected_results.push_back(r);
        endfunction

        // One accepted input byte
        function void note_rx_byte(logic [7:0] b);
            frame_result_t r;
            unique case (phase)
                slcd_pkg::ST_SYNC_B:
                begin
                    // second sync wins when both sync values are equal
                    if (b == sync_second)
                        phase = slcd_pkg::ST_TYPE;
                    else if (b != sync_first)
                        phase = slcd_pkg::ST_SYNC_A;
                end
                slcd_pkg::ST_TYPE:
                begin
                    held_type = b;
                    crc       = crc_update(slcd_pkg::CRC_INIT, b);
                    phase     = slcd_pkg::ST_LEN;
                end
                slcd_pkg::ST_LEN:
                begin
                    crc    = crc_update(crc, b);
                    wr_pos = '0;
                    if (int'(b) + 1 > BUFFER_BYTES - 2)
                    begin
                        // oversized: drop silently
                        phase = slcd_pkg::ST_SYNC_A;
                    end
                    else
                    begin
                        held_len   = b[5:0];
                        bytes_left = 7'(int'(b) + 1);
                        phase      = slcd_pkg::ST_BODY;
                    end
                end
                slcd_pkg::ST_BODY:
                begin
                    if (bytes_left > 1)
                    begin
                        if (wr_pos < STORE_DEPTH)
                            store[wr_pos] = b;
                        crc        = crc_update(crc, b);
                        wr_pos     = wr_pos + 1'b1;
                        bytes_left = bytes_left - 1'b1;
                    end
                    else
                    begin
                        // CRC byte ends the frame either way
                        phase      = slcd_pkg::ST_SYNC_A;
                        bytes_left = '0;
                        if (b == crc)
                        begin
                            if (held_len == 0)
                            begin
                                r = '{held_type, 6'd0, 8'd0, 6'd0, 1'b1, 1'b1};
                                push_result(r);
                            end
                            else
                            begin
                                for (int k = 0; k < held_len && k < STORE_DEPTH; k++)
                                begin
                                    r = '{held_type, held_len, store[k], 6'(k), 1'b0,
                                          (k + 1 == held_len)};
                                    push_result(r);
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    phase = (b == sync_first) ? slcd_pkg::ST_SYNC_B : slcd_pkg::ST_SYNC_A;
                end
            endcase
        endfunction

        // One result transfer
        function void check_result(frame_result_t got);
            frame_result_t want;
            if (expected_results.size() == 0)
            begin
                fail({"result with nothing expected: ", show(got)});
                return;
            end
            want = expected_results.pop_front();
            if (got !== want)
                fail({"mismatch: expected ", show(want), " got ", show(got)});
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        function void check_drained();
            if (expected_results.size() != 0)
                fail($sformatf("%0d expected results never arrived", expected_results.size()));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [slcd_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [7:0]                     cfg_wdata;

    slcd_rx_if  rx_ch ();
    slcd_res_if res_ch ();

    sync_length_crc8_deframer #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rx_ch     (rx_ch),
        .res_ch    (res_ch)
    );

    frame_scoreboard sb = new();

    logic [7:0] sync_first_val;
    logic [7:0] sync_second_val;
    bit         quiet_frame;
    int         bytes_sent;
    int         phase_start;
    int         random_start;

    always #5 clk = ~clk;

    // Sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet_frame)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Offer one byte; returns after the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.rx_byte = b;
        rx_ch.valid   = 1'b1;
        do
            @(posedge clk);
        while (!(rx_ch.valid && rx_ch.ready));
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    // Hold off input until every expected result is out, then let the block settle
    task automatic drain();
        @(negedge clk);
        rx_ch.valid = 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [slcd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic set_syncs(input logic [7:0] first, input logic [7:0] second);
        drain();
        cfg_write(slcd_pkg::REG_SYNC_FIRST, first);
        cfg_write(slcd_pkg::REG_SYNC_SECOND, second);
        sync_first_val  = first;
        sync_second_val = second;
    endtask

    // Sync (with extra first-sync repeats), type, length, payload, CRC.
    // Lengths past the store stop after the length byte.
    task automatic send_frame(input logic [7:0] typ, input int len, input int reps,
                              input logic [7:0] crc_flip);
        logic [7:0] frame_bytes [$];
        logic [7:0] crc;
        logic [7:0] d;
        frame_bytes.push_back(sync_first_val);
        repeat (reps) frame_bytes.push_back(sync_first_val);
        frame_bytes.push_back(sync_second_val);
        frame_bytes.push_back(typ);
        frame_bytes.push_back(8'(len));
        if (len <= STORE_DEPTH)
        begin
            crc = frame_scoreboard::crc_update(slcd_pkg::CRC_INIT, typ);
            crc = frame_scoreboard::crc_update(crc, 8'(len));
            repeat (len)
            begin
                d = 8'($urandom_range(0, 255));
                frame_bytes.push_back(d);
                crc = frame_scoreboard::crc_update(crc, d);
            end
            frame_bytes.push_back(crc ^ crc_flip);
        end
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    // Mostly good frames, some bad CRC, oversized length or line noise
    task automatic send_random_frame(input int force_len);
        int kind;
        int len;
        int reps;
        kind        = (force_len >= 0) ? 0 : $urandom_range(0, 99);
        quiet_frame = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0)
            drain();
        if (kind >= 85)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            reps = 0;
            if (sync_first_val != sync_second_val && $urandom_range(0, 4) == 0)
                reps = $urandom_range(1, 3);
            if (kind >= 75)
                len = $urandom_range(STORE_DEPTH + 1, 255);
            else if (force_len >= 0)
                len = force_len;
            else if ($urandom_range(0, 11) == 0)
                len = $urandom_range(50, STORE_DEPTH);
            else
                len = $urandom_range(0, 8);
            send_frame(8'($urandom_range(0, 255)), len, reps,
                       (kind >= 65) ? 8'($urandom_range(1, 255)) : 8'h00);
        end
    endtask

    // Result side: random stall pattern
    initial
    begin : result_stall
        int run;
        int stall;
        int r;
        res_ch.ready = 1'b0;
        forever
        begin
            run   = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
            r     = $urandom_range(0, 99);
            stall = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 30);
            repeat (run)
            begin
                @(negedge clk);
                res_ch.ready = 1'b1;
            end
            repeat (stall)
            begin
                @(negedge clk);
                res_ch.ready = 1'b0;
            end
        end
    end

    // Result side: check every transfer
    initial
    begin : result_monitor
        frame_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.frame_type     = res_ch.frame_type;
                got.payload_length = res_ch.payload_length;
                got.payload_byte   = res_ch.payload_byte;
                got.byte_position  = res_ch.byte_position;
                got.empty_payload  = res_ch.empty_payload;
                got.last_of_frame  = res_ch.last_of_frame;
                sb.check_result(got);
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = slcd_pkg::REG_SYNC_FIRST;
        cfg_wdata       = '0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = '0;
        sync_first_val  = slcd_pkg::SYNC_FIRST_RST;
        sync_second_val = slcd_pkg::SYNC_SECOND_RST;
        quiet_frame     = 1'b0;
        bytes_sent      = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty payload after a repeated first sync, one-byte frame,
        // bad CRC, smallest and largest oversized length, broken sync
        send_frame(8'h00, 0, 1, 8'h00);
        send_frame(8'hFF, 1, 0, 8'h00);
        send_frame(8'h12, 0, 0, 8'hFF);
        send_frame(8'h34, STORE_DEPTH + 1, 0, 8'h00);
        send_frame(8'h56, 255, 0, 8'h00);
        send_byte(sync_first_val);
        send_byte(8'h00);

        // Random frames under several sync settings, equal values among them
        random_start = bytes_sent;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_syncs(8'h00, 8'hFF);
                1: set_syncs(8'hFF, 8'h00);
                2: set_syncs(8'h5A, 8'h5A);
                default: set_syncs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            phase_start = bytes_sent;
            if (ph == 0)
                send_random_frame(STORE_DEPTH);
            while (bytes_sent - phase_start < 6 ||
                   (ph == 3 && bytes_sent - random_start < 80))
                send_random_frame(-1);
        end

        drain();
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #50000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
